// File: design/bbw_pkg.sv
// Shared types, constants and helper functions for the wrap-around box blur.
`default_nettype none
package bbw_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PIX_W      = 24;

  // Field and arithmetic widths
  localparam int COORD_W = 8;
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 9;
  localparam int WGT_W   = 16;
  localparam int SUM_W   = 12;
  localparam int PROD_W  = SUM_W + WGT_W;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(256);
  localparam logic [WGT_W-1:0] WEIGHT_RST = WGT_W'(6554);

  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WEIGHT = 2'd2
  } reg_idx_t;

  // Request functions
  typedef enum logic {
    FN_LOAD  = 1'b0,
    FN_QUERY = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_MUL,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              range_error;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [WGT_W-1:0] tap_weight;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } mem_req_t;

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (int'(v) > maxv) r = CFG_W'(maxv);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

  // Truncate the Q12.16 product to an integer and saturate
  function automatic logic [CHAN_W-1:0] sat_chan(input logic [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-1:0] ip;
    ip = p[PROD_W-1:FRAC_W];
    return (ip > (PROD_W-FRAC_W)'(CHAN_MAX)) ? CHAN_MAX : ip[CHAN_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/bbw_frame_ram.sv
// Single-port synchronous frame memory with registered read data.
`default_nettype none
module bbw_frame_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 24
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write on enable, otherwise register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

// File: design/bbw_ctrl.sv
// Request sequencer: pixel loads, nine-tap neighbourhood reads, weighting and result register.
`default_nettype none
module bbw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bbw_pkg::cfg_t       cfg,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bbw_pkg::in_item_t   req_data,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output bbw_pkg::out_item_t       rsp_data,
  output bbw_pkg::mem_req_t        mem_req,
  input  wire logic [bbw_pkg::PIX_W-1:0] mem_rdata
);
  import bbw_pkg::*;

  state_t state, state_next;

  logic [1:0]       ri, ci;
  logic [CFG_W-1:0] row_p, row_c, row_n;
  logic [CFG_W-1:0] col_p, col_c, col_n;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic             rd_pending;
  logic             err;

  logic [CFG_W-1:0] w, h, row9, col9, row_inc, col_inc;
  logic [CFG_W-1:0] tap_row, tap_col;
  logic             accept, in_range, last_tap, slot_free;
  out_item_t        res;

  // Frame size and request decode
  assign w       = clamp_size(cfg.frame_width, MAX_WIDTH);
  assign h       = clamp_size(cfg.frame_height, MAX_HEIGHT);
  assign row9    = {1'b0, req_data.row};
  assign col9    = {1'b0, req_data.col};
  assign row_inc = row9 + CFG_W'(1);
  assign col_inc = col9 + CFG_W'(1);
  assign in_range = (row9 < h) && (col9 < w);
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign last_tap  = (ri == 2'd2) && (ci == 2'd2);
  assign slot_free = !rsp_valid || rsp_ready;

  // Select the neighbour for the current tap
  always_comb begin
    case (ri)
      2'd0:    tap_row = row_p;
      2'd1:    tap_row = row_c;
      default: tap_row = row_n;
    endcase
    case (ci)
      2'd0:    tap_col = col_p;
      2'd1:    tap_col = col_c;
      default: tap_col = col_n;
    endcase
  end

  // Result word: error or saturated weighted sums
  always_comb begin
    if (err) begin
      res = '{red_out: '0, green_out: '0, blue_out: '0, range_error: 1'b1};
    end else begin
      res = '{red_out: sat_chan(prod_r), green_out: sat_chan(prod_g),
              blue_out: sat_chan(prod_b), range_error: 1'b0};
    end
  end

  // Next state and memory request
  always_comb begin
    state_next    = state;
    mem_req.we    = 1'b0;
    mem_req.addr  = pix_addr(tap_row, tap_col);
    mem_req.wdata = {req_data.red_in, req_data.green_in, req_data.blue_in};
    case (state)
      ST_IDLE: begin
        mem_req.addr = pix_addr(row9, col9);
        if (accept) begin
          if (!in_range) begin
            state_next = ST_PUSH;
          end else if (req_data.func == FN_QUERY) begin
            state_next = ST_READ;
          end else begin
            mem_req.we = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (last_tap) state_next = ST_LAST;
      end
      ST_LAST: state_next = ST_MUL;
      ST_MUL:  state_next = ST_PUSH;
      ST_PUSH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == ST_READ);
      if (state == ST_PUSH && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath: latch neighbours, step taps, accumulate, weight, hold result
  always_ff @(posedge clk) begin
    if (accept) begin
      err   <= !in_range;
      ri    <= 2'd0;
      ci    <= 2'd0;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      row_c <= row9;
      col_c <= col9;
      row_p <= (req_data.row == '0) ? h - CFG_W'(1) : row9 - CFG_W'(1);
      col_p <= (req_data.col == '0) ? w - CFG_W'(1) : col9 - CFG_W'(1);
      row_n <= (row_inc >= h) ? '0 : row_inc;
      col_n <= (col_inc >= w) ? '0 : col_inc;
    end else begin
      if (state == ST_READ) begin
        if (ci == 2'd2) begin
          ci <= 2'd0;
          ri <= ri + 2'd1;
        end else begin
          ci <= ci + 2'd1;
        end
      end
      if (rd_pending) begin
        sum_r <= sum_r + SUM_W'(mem_rdata[23:16]);
        sum_g <= sum_g + SUM_W'(mem_rdata[15:8]);
        sum_b <= sum_b + SUM_W'(mem_rdata[7:0]);
      end
    end
    if (state == ST_MUL) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(cfg.tap_weight);
      prod_g <= PROD_W'(sum_g) * PROD_W'(cfg.tap_weight);
      prod_b <= PROD_W'(sum_b) * PROD_W'(cfg.tap_weight);
    end
    if (state == ST_PUSH && slot_free) begin
      rsp_data <= res;
    end
  end

  // Stores happen only while idle
  assert property (@(posedge clk) disable iff (rst) mem_req.we |-> state == ST_IDLE)
    else $error("frame write outside idle");

  // Read data is consumed only in the cycle after a tap was issued
  assert property (@(posedge clk) disable iff (rst) rd_pending |-> $past(state) == ST_READ)
    else $error("accumulate without a pending read");

  // The ninth tap hands over to the final accumulate
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_READ && last_tap) |=> state == ST_LAST)
    else $error("tap sequence overran");

  // An error result carries zero channels
  assert property (@(posedge clk) disable iff (rst)
                   (rsp_valid && rsp_data.range_error) |->
                   (rsp_data.red_out == '0 && rsp_data.green_out == '0 &&
                    rsp_data.blue_out == '0))
    else $error("error result with non-zero channels");

endmodule
`default_nettype wire

// File: design/box_blur_3x3_wrap_core.sv
// Top level of the wrap-around 3x3 box blur: configuration registers and frame store.
//
// Requests arrive on req_valid/req_ready with a packed in_item_t. A load
// request (func 0) writes one RGB pixel to the frame store in its accept
// cycle and gives no result, unless its coordinate lies outside the
// configured frame. A query request (func 1) reads the nine neighbours of
// the pixel, rows and columns wrapping at the frame edges, one per cycle
// from the single-port frame memory, then weights each channel sum once
// by tap_weight and saturates it at 255.
// A query steps through nine memory reads, one final accumulate, one multiply
// and one result load, paced by the single memory port; no new request is
// taken until its result has moved to the output register. An out-of-range
// request returns range_error with zero channels.
// Results leave on rsp_valid/rsp_ready from an output register; a finished
// result waits there while the next request is accepted and worked on.
// If the receiver stalls, the following result waits in the sequencer
// and no new request is taken until it moves out.
// Reset sets width and height to 256 and the weight to 6554; the frame
// store is not cleared, and a pixel must be loaded before it is read.
// Configuration writes (cfg_valid/cfg_ready) are taken in any cycle.
`default_nettype none
module box_blur_3x3_wrap_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire bbw_pkg::in_item_t           req_data,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output bbw_pkg::out_item_t               rsp_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bbw_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bbw_pkg::DATA_W-1:0]  cfg_data
);
  import bbw_pkg::*;

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [PIX_W-1:0]  mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= WIDTH_RST;
      cfg.frame_height <= HEIGHT_RST;
      cfg.tap_weight   <= WEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  cfg.frame_width  <= cfg_data[CFG_W-1:0];
        REG_HEIGHT: cfg.frame_height <= cfg_data[CFG_W-1:0];
        REG_WEIGHT: cfg.tap_weight   <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  bbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bbw_frame_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire
